// File: hdl/assert_macros.svh
// assertion macros used by the checker file
// depends on clk and arst_n being visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds on every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/hsvrgb_pkg.sv
`timescale 1ns / 1ps
// types and constants for the hsv to rgb converter
// no dependencies
package hsvrgb_pkg;

	localparam int unsigned FRACTION_BITS_DEF = 15;
	localparam int unsigned QBITS = 15;
	localparam logic [15:0] QONE = 16'd32768;
	localparam logic [15:0] HUE_FULL = 16'd23040;
	localparam int unsigned HUE_SECTOR = 3840;
	// 3840 = 15 << 8
	localparam int unsigned HUE_SECTOR_SHIFT = 8;
	localparam int unsigned HUE_SECTOR_ODD = 15;
	localparam int unsigned SECTOR_W = 3;

	// 60 degree sectors
	localparam logic [SECTOR_W-1:0] SEC_RY = 3'd0;
	localparam logic [SECTOR_W-1:0] SEC_YG = 3'd1;
	localparam logic [SECTOR_W-1:0] SEC_GC = 3'd2;
	localparam logic [SECTOR_W-1:0] SEC_CB = 3'd3;
	localparam logic [SECTOR_W-1:0] SEC_BM = 3'd4;
	localparam logic [SECTOR_W-1:0] SEC_MR = 3'd5;

	typedef struct packed {
		logic [15:0] hue;
		logic [15:0] saturation;
		logic [15:0] brightness;
	} hsv_t;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} rgb_t;

	// side data that travels with the hue fraction
	typedef struct packed {
		logic [SECTOR_W-1:0] sector;
		logic                grey;
		logic [15:0]         sat;
		logic [15:0]         val;
	} lvl_t;

endpackage

// File: hdl/hsv_to_rgb_converter_unit.sv
`timescale 1ns / 1ps
// channel | signals                        | moves
// hsv     | hsv_valid, hsv_ready, hsv      | request: hue, saturation, brightness
// rgb     | rgb_valid, rgb_ready, rgb      | result: red, green, blue
//
// seven register stages, one request accepted per clock unless a stall has filled them
// a request taken into stage 1 is registered through stages 2 to 7 before its result is valid
// full rate holds since every stage advances whenever the next is empty or moving on
// reset clears only the stage valid bits, data registers are not reset
// a stall holds each full stage, empty stages in front keep filling
// depends on hsvrgb_pkg and hsvrgb_hue
module hsv_to_rgb_converter_unit #(
	parameter int unsigned FRACTION_BITS = hsvrgb_pkg::FRACTION_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             hsv_valid,
	output logic             hsv_ready,
	input  hsvrgb_pkg::hsv_t hsv,
	output logic             rgb_valid,
	input  logic             rgb_ready,
	output hsvrgb_pkg::rgb_t rgb
);
	import hsvrgb_pkg::*;

	localparam int unsigned FB = FRACTION_BITS;

	logic              frac_valid;
	lvl_t              lvl;
	logic [FB-1:0]     frac;

	logic vld_s4, vld_s5, vld_s6, vld_s7;
	logic rdy_s4, rdy_s5, rdy_s6, rdy_s7;

	assign rdy_s7 = !vld_s7 || rgb_ready;
	assign rdy_s6 = !vld_s6 || rdy_s7;
	assign rdy_s5 = !vld_s5 || rdy_s6;
	assign rdy_s4 = !vld_s4 || rdy_s5;

	hsvrgb_hue #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_hue (
		.clk       (clk),
		.arst_n    (arst_n),
		.hsv_valid (hsv_valid),
		.hsv_ready (hsv_ready),
		.hsv       (hsv),
		.frac_valid(frac_valid),
		.frac_ready(rdy_s4),
		.lvl       (lvl),
		.frac      (frac)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (rdy_s4) vld_s4 <= frac_valid;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
			if (rdy_s7) vld_s7 <= vld_s6;
		end
	end

	// stage 4: s*f and s*(1-f)
	lvl_t           lvl_s4;
	logic [FB+15:0] sf_prod_s4;
	logic [FB+16:0] snf_prod_s4;
	logic [FB:0]    nf_w;

	assign nf_w = {1'b1, {FB{1'b0}}} - (FB+1)'(frac);

	always_ff @(posedge clk) begin
		if (rdy_s4 && frac_valid) begin
			lvl_s4 <= lvl;
			sf_prod_s4 <= (FB+16)'(lvl.sat) * (FB+16)'(frac);
			snf_prod_s4 <= (FB+17)'(lvl.sat) * (FB+17)'(nf_w);
		end
	end

	// stage 5: the three multiplier arguments 1-s, 1-sf, 1-s(1-f)
	lvl_t        lvl_s5;
	logic [15:0] pa_s5, qa_s5, ta_s5;

	always_ff @(posedge clk) begin
		if (rdy_s5 && vld_s4) begin
			lvl_s5 <= lvl_s4;
			pa_s5 <= QONE - lvl_s4.sat;
			qa_s5 <= QONE - sf_prod_s4[FB+15:FB];
			ta_s5 <= QONE - snf_prod_s4[FB+15:FB];
		end
	end

	// stage 6: scale by v, all products stay below 2^31
	lvl_t        lvl_s6;
	logic [15:0] p_s6, q_s6, t_s6;
	logic [31:0] pv_w, qv_w, tv_w;

	always_comb begin
		pv_w = 32'(lvl_s5.val) * 32'(pa_s5);
		qv_w = 32'(lvl_s5.val) * 32'(qa_s5);
		tv_w = 32'(lvl_s5.val) * 32'(ta_s5);
	end

	always_ff @(posedge clk) begin
		if (rdy_s6 && vld_s5) begin
			lvl_s6 <= lvl_s5;
			p_s6 <= pv_w[QBITS+15:QBITS];
			q_s6 <= qv_w[QBITS+15:QBITS];
			t_s6 <= tv_w[QBITS+15:QBITS];
		end
	end

	// stage 7: sector routing, grey bypass, output register
	rgb_t rgb_w, rgb_s7;
	logic [15:0] v_w;

	always_comb begin
		v_w = lvl_s6.val;
		unique case (lvl_s6.sector)
			SEC_RY:  rgb_w = '{red: v_w,  green: t_s6, blue: p_s6};
			SEC_YG:  rgb_w = '{red: q_s6, green: v_w,  blue: p_s6};
			SEC_GC:  rgb_w = '{red: p_s6, green: v_w,  blue: t_s6};
			SEC_CB:  rgb_w = '{red: p_s6, green: q_s6, blue: v_w};
			SEC_BM:  rgb_w = '{red: t_s6, green: p_s6, blue: v_w};
			default: rgb_w = '{red: v_w,  green: p_s6, blue: q_s6};
		endcase
		if (lvl_s6.grey) begin
			rgb_w = '{red: v_w, green: v_w, blue: v_w};
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s7 && vld_s6) begin
			rgb_s7 <= rgb_w;
		end
	end

	assign rgb_valid = vld_s7;
	assign rgb = rgb_s7;

endmodule

// File: hdl/hsvrgb_hue.sv
`timescale 1ns / 1ps
// hue front end: clamps, sector split and fraction f = rem * 2^fb / 3840
// three pipeline stages, depends on hsvrgb_pkg
module hsvrgb_hue #(
	parameter int unsigned FRACTION_BITS = hsvrgb_pkg::FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     hsv_valid,
	output logic                     hsv_ready,
	input  hsvrgb_pkg::hsv_t         hsv,
	output logic                     frac_valid,
	input  logic                     frac_ready,
	output hsvrgb_pkg::lvl_t         lvl,
	output logic [FRACTION_BITS-1:0] frac
);
	import hsvrgb_pkg::*;

	localparam int unsigned XW = FRACTION_BITS + 4;
	localparam int unsigned DIV_K = XW;
	localparam int unsigned MW = FRACTION_BITS + 1;
	localparam int unsigned PW = XW + MW;
	localparam logic [MW-1:0] DIV_M = MW'((64'd1 << DIV_K) / HUE_SECTOR_ODD);

	logic vld_s1, vld_s2, vld_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	lvl_t        lvl_s1, lvl_s2, lvl_s3;
	logic [11:0] rem_s1;
	logic [XW-1:0] x_s2;
	logic [PW-1:0] prod_s2;
	logic [FRACTION_BITS-1:0] frac_s3;

	assign rdy_s3 = !vld_s3 || frac_ready;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign hsv_ready = rdy_s1;

	// stage 1: clamps, hue wrap, sector search
	logic [15:0]         h_w, base_w;
	logic [SECTOR_W-1:0] sec_w;
	logic [15:0]         s_w, v_w;

	always_comb begin
		h_w = (hsv.hue >= HUE_FULL) ? 16'd0 : hsv.hue;
		s_w = (hsv.saturation > QONE) ? QONE : hsv.saturation;
		v_w = (hsv.brightness > QONE) ? QONE : hsv.brightness;
		sec_w = SEC_RY;
		base_w = 16'd0;
		for (int k = 1; k < 6; k++) begin
			if (h_w >= 16'(k * HUE_SECTOR)) begin
				sec_w = SECTOR_W'(k);
				base_w = 16'(k * HUE_SECTOR);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= hsv_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && hsv_valid) begin
			lvl_s1.sector <= sec_w;
			lvl_s1.grey <= (s_w == 16'd0);
			lvl_s1.sat <= s_w;
			lvl_s1.val <= v_w;
			rem_s1 <= 12'(h_w - base_w);
		end
	end

	// stage 2: divide by 15 through a reciprocal multiply
	logic [XW-1:0] x_w;
	assign x_w = XW'(rem_s1) << (FRACTION_BITS - HUE_SECTOR_SHIFT);

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			lvl_s2 <= lvl_s1;
			x_s2 <= x_w;
			prod_s2 <= PW'(x_w) * PW'(DIV_M);
		end
	end

	// stage 3: estimate is low by at most one, fix it with the remainder
	logic [MW-1:0] q0_w;
	logic [XW:0]   q15_w, r_w;
	logic [MW-1:0] q_w;

	always_comb begin
		q0_w = prod_s2[PW-1:DIV_K];
		q15_w = {q0_w, 4'b0000} - (XW+1)'(q0_w);
		r_w = (XW+1)'(x_s2) - q15_w;
		q_w = (r_w >= (XW+1)'(HUE_SECTOR_ODD)) ? q0_w + MW'(1) : q0_w;
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			lvl_s3 <= lvl_s2;
			frac_s3 <= q_w[FRACTION_BITS-1:0];
		end
	end

	assign frac_valid = vld_s3;
	assign lvl = lvl_s3;
	assign frac = frac_s3;

endmodule

// File: hdl/hsvrgb_checker.sv
`timescale 1ns / 1ps
// port level checks for the hsv to rgb converter, bound to the top level
// depends on hsvrgb_pkg and assert_macros.svh
`include "assert_macros.svh"

module hsvrgb_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             hsv_valid,
	input logic             hsv_ready,
	input hsvrgb_pkg::hsv_t hsv,
	input logic             rgb_valid,
	input logic             rgb_ready,
	input hsvrgb_pkg::rgb_t rgb
);
	import hsvrgb_pkg::*;

	logic rgb_in_range;
	assign rgb_in_range = rgb.red <= QONE && rgb.green <= QONE && rgb.blue <= QONE;

	// every level is a Q1.15 value no greater than one
	`ASSERT_ALWAYS(a_rgb_range, !rgb_valid || rgb_in_range, "rgb component above one")

	// the pipeline only refuses a request when it is full and the output is held
	`ASSERT_ALWAYS(a_full_stall, hsv_ready || (rgb_valid && !rgb_ready), "refused, no stall")

	// a held result keeps its value
	`ASSERT_NEXT(a_rgb_hold, rgb_valid && !rgb_ready, rgb_valid && $stable(rgb), "held result changed")

	// a waiting request keeps its value
	`ASSERT_NEXT(a_hsv_hold, hsv_valid && !hsv_ready, hsv_valid && $stable(hsv), "request changed")

	// a result only leaves through a handshake
	`ASSERT_ALWAYS(a_rgb_drop, !$fell(rgb_valid) || $past(rgb_ready), "result dropped")

endmodule

bind hsv_to_rgb_converter_unit hsvrgb_checker u_hsvrgb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.hsv_valid(hsv_valid),
	.hsv_ready(hsv_ready),
	.hsv      (hsv),
	.rgb_valid(rgb_valid),
	.rgb_ready(rgb_ready),
	.rgb      (rgb)
);

// File: verif/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for hsv_to_rgb_converter_unit: a directed table, then random colours
// results are checked against table values or a fixed-point hsv to rgb predictor held here
// depends on hsvrgb_pkg and the converter rtl
module testbench;
	import hsvrgb_pkg::*;

	localparam int unsigned FRAC_BITS = FRACTION_BITS_DEF;
	localparam int unsigned RANDOM_COLOURS = 1500;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_CYCLES = 20;

	typedef struct packed {
		hsv_t stim;
		logic known;
		rgb_t want;
	} colour_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic hsv_valid = 1'b0;
	logic hsv_ready;
	hsv_t hsv = '0;
	logic rgb_valid;
	logic rgb_ready = 1'b0;
	rgb_t rgb;

	rgb_t expected_colours[$];
	colour_row_t directed_rows[$];
	logic steady = 1'b0;
	int unsigned cycles = 0;
	int unsigned mismatches = 0;
	int unsigned colours_checked = 0;
	int unsigned requests_sent = 0;
	int unsigned grey_requests = 0;
	int unsigned clamped_requests = 0;
	int unsigned wrapped_hues = 0;

	hsv_to_rgb_converter_unit #(
		.FRACTION_BITS(FRAC_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.hsv_valid(hsv_valid),
		.hsv_ready(hsv_ready),
		.hsv(hsv),
		.rgb_valid(rgb_valid),
		.rgb_ready(rgb_ready),
		.rgb(rgb)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				expected_colours.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic logic [63:0] clamp_q15(logic [15:0] x);
		return (x > QONE) ? 64'(QONE) : 64'(x);
	endfunction

	function automatic rgb_t hsv_to_rgb_fixed(hsv_t c);
		logic [63:0] h, s, v, rem, f, sf, snf, p, q, t;
		logic [SECTOR_W-1:0] sector;
		rgb_t o;
		h = 64'(c.hue);
		s = clamp_q15(c.saturation);
		v = clamp_q15(c.brightness);
		if (s == 0) begin
			o.red = v[15:0];
			o.green = v[15:0];
			o.blue = v[15:0];
			return o;
		end
		if (h >= 64'(HUE_FULL))
			h = 0;
		sector = SECTOR_W'(h / HUE_SECTOR);
		rem = h % HUE_SECTOR;
		f = (rem << FRAC_BITS) / HUE_SECTOR;
		sf = (s * f) >> FRAC_BITS;
		snf = (s * ((64'd1 << FRAC_BITS) - f)) >> FRAC_BITS;
		p = (v * (64'(QONE) - s)) >> QBITS;
		q = (v * (64'(QONE) - sf)) >> QBITS;
		t = (v * (64'(QONE) - snf)) >> QBITS;
		case (sector)
			SEC_RY: o = {v[15:0], t[15:0], p[15:0]};
			SEC_YG: o = {q[15:0], v[15:0], p[15:0]};
			SEC_GC: o = {p[15:0], v[15:0], t[15:0]};
			SEC_CB: o = {p[15:0], q[15:0], v[15:0]};
			SEC_BM: o = {t[15:0], p[15:0], v[15:0]};
			default: o = {v[15:0], p[15:0], q[15:0]};
		endcase
		return o;
	endfunction

	function automatic colour_row_t row(int unsigned h, int unsigned s, int unsigned v,
		logic known, int unsigned r = 0, int unsigned g = 0, int unsigned b = 0);
		colour_row_t x;
		x.stim = {16'(h), 16'(s), 16'(v)};
		x.known = known;
		x.want = {16'(r), 16'(g), 16'(b)};
		return x;
	endfunction

	function automatic hsv_t random_colour();
		hsv_t c;
		c.hue = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, HUE_FULL - 1))
			: 16'($urandom_range(0, 65535));
		case ($urandom_range(0, 19))
			0, 1: c.saturation = '0;
			2, 3, 4: c.saturation = 16'($urandom_range(0, 65535));
			5: c.saturation = QONE;
			default: c.saturation = 16'($urandom_range(1, QONE));
		endcase
		case ($urandom_range(0, 19))
			0, 1, 2: c.brightness = 16'($urandom_range(0, 65535));
			3: c.brightness = QONE;
			default: c.brightness = 16'($urandom_range(0, QONE));
		endcase
		return c;
	endfunction

	// holds the request until accepted, then files its expected colour
	task automatic send_request(hsv_t c, rgb_t want);
		hsv <= c;
		hsv_valid <= 1'b1;
		@(posedge clk);
		while (!hsv_ready)
			@(posedge clk);
		expected_colours.push_back(want);
		requests_sent++;
		if (clamp_q15(c.saturation) == 0)
			grey_requests++;
		if (c.saturation > QONE || c.brightness > QONE)
			clamped_requests++;
		if (c.hue >= HUE_FULL)
			wrapped_hues++;
	endtask

	task automatic maybe_idle();
		if (!steady && $urandom_range(0, 99) < 9) begin
			hsv_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain_pipeline();
		hsv_valid <= 1'b0;
		while (expected_colours.size() != 0)
			@(posedge clk);
	endtask

	task automatic flag_error(string why, rgb_t want, rgb_t got);
		if (mismatches < 10)
			$display("%s at cycle %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
				why, cycles, want.red, want.green, want.blue, got.red, got.green, got.blue);
		mismatches++;
	endtask

	// receiver back-pressure, with a quiet stretch while steady is set
	always @(posedge clk)
		rgb_ready <= steady || ($urandom_range(0, 99) >= 9);

	always @(posedge clk) begin
		rgb_t want;
		if (arst_n && rgb_valid && rgb_ready) begin
			if (expected_colours.size() == 0) begin
				flag_error("unexpected colour", '0, rgb);
			end else begin
				want = expected_colours.pop_front();
				colours_checked++;
				if (rgb.red !== want.red || rgb.green !== want.green || rgb.blue !== want.blue)
					flag_error("colour mismatch", want, rgb);
			end
		end
	end

	initial begin
		hsv_t c;
		directed_rows = '{
			row(0, 0, 0, 1'b1, 0, 0, 0),
			row(0, 0, 32768, 1'b1, 32768, 32768, 32768),
			row(12345, 0, 20000, 1'b1, 20000, 20000, 20000),
			row(65535, 0, 65535, 1'b1, 32768, 32768, 32768),
			row(0, 32768, 32768, 1'b1, 32768, 0, 0),
			row(3840, 32768, 32768, 1'b1, 32768, 32768, 0),
			row(7680, 32768, 32768, 1'b1, 0, 32768, 0),
			row(11520, 32768, 32768, 1'b1, 0, 32768, 32768),
			row(15360, 32768, 32768, 1'b1, 0, 0, 32768),
			row(19200, 32768, 32768, 1'b1, 32768, 0, 32768),
			// full circle and beyond wrap to red
			row(23040, 32768, 32768, 1'b1, 32768, 0, 0),
			row(65535, 32768, 32768, 1'b1, 32768, 0, 0),
			row(0, 65535, 32768, 1'b1, 32768, 0, 0),
			row(7680, 32768, 65535, 1'b1, 0, 32768, 0),
			row(0, 32768, 0, 1'b1, 0, 0, 0),
			row(3839, 32768, 32768, 1'b0),
			row(23039, 32768, 32768, 1'b0),
			row(1920, 16384, 32768, 1'b0),
			row(9600, 1, 1, 1'b0),
			row(17280, 32767, 32767, 1'b0),
			row(13440, 32769, 32769, 1'b0),
			row(23041, 12345, 30000, 1'b0),
			row(5000, 1, 32768, 1'b0)
		};
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_request(directed_rows[i].stim, directed_rows[i].known ? directed_rows[i].want
				: hsv_to_rgb_fixed(directed_rows[i].stim));
			maybe_idle();
		end
		drain_pipeline();

		for (int unsigned i = 0; i < RANDOM_COLOURS; i++) begin
			steady <= (i >= 500 && i < 800);
			c = random_colour();
			send_request(c, hsv_to_rgb_fixed(c));
			if (i == 1000)
				drain_pipeline();
			else
				maybe_idle();
		end
		steady <= 1'b0;
		drain_pipeline();
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("covered %0d requests (%0d from the table), %0d colours checked",
			requests_sent, directed_rows.size(), colours_checked);
		$display("grey %0d, clamped inputs %0d, hues past full circle %0d",
			grey_requests, clamped_requests, wrapped_hues);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// File: hsv_to_rgb_converter_unit.f
+incdir+hdl
hdl/hsvrgb_pkg.sv
hdl/hsvrgb_hue.sv
hdl/hsv_to_rgb_converter_unit.sv
hdl/hsvrgb_checker.sv
verif/testbench.sv
